// File: rtl/cpu_alu_and_bit_unit_8bit_core_macros.svh
// Assertion macros for the ALU and bit unit RTL, included by the top level.
// Defining ASSERT_OFF turns every assertion into an empty statement.
`ifndef CPU_ALU_AND_BIT_UNIT_8BIT_CORE_MACROS_SVH
`define CPU_ALU_AND_BIT_UNIT_8BIT_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define CABU8_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define CABU8_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CABU8_ASSERT(label, prop, msg)
`define CABU8_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// File: rtl/cabu8_pkg.sv
// Types and constants of the 8-bit ALU and CB bit unit.
// Used by every module of the block; depends on nothing.
package cabu8_pkg;

	localparam logic [3:0] MODE_ADD = 4'd0;
	localparam logic [3:0] MODE_ADC = 4'd1;
	localparam logic [3:0] MODE_SUB = 4'd2;
	localparam logic [3:0] MODE_SBC = 4'd3;
	localparam logic [3:0] MODE_AND = 4'd4;
	localparam logic [3:0] MODE_XOR = 4'd5;
	localparam logic [3:0] MODE_OR  = 4'd6;
	localparam logic [3:0] MODE_CP  = 4'd7;
	localparam logic [3:0] MODE_INC = 4'd8;
	localparam logic [3:0] MODE_DEC = 4'd9;
	localparam logic [3:0] MODE_CB  = 4'd10;

	localparam int FLAG_Z = 3;
	localparam int FLAG_N = 2;
	localparam int FLAG_H = 1;
	localparam int FLAG_C = 0;

	localparam logic [1:0] CB_GRP_SHIFT = 2'd0;
	localparam logic [1:0] CB_GRP_BIT   = 2'd1;
	localparam logic [1:0] CB_GRP_RES   = 2'd2;
	localparam logic [1:0] CB_GRP_SET   = 2'd3;

	localparam logic [2:0] CB_RLC  = 3'd0;
	localparam logic [2:0] CB_RRC  = 3'd1;
	localparam logic [2:0] CB_RL   = 3'd2;
	localparam logic [2:0] CB_RR   = 3'd3;
	localparam logic [2:0] CB_SLA  = 3'd4;
	localparam logic [2:0] CB_SRA  = 3'd5;
	localparam logic [2:0] CB_SWAP = 3'd6;
	localparam logic [2:0] CB_SRL  = 3'd7;

	typedef struct packed {
		logic [3:0] mode;
		logic [7:0] operand_a;
		logic [7:0] operand_b;
		logic [3:0] flags_in;
	} req_t;

	typedef struct packed {
		logic [7:0] result;
		logic [3:0] flags_out;
		logic       result_written;
	} rsp_t;

	function automatic logic [3:0] pack_flags(input logic z, input logic n,
		input logic h, input logic c);
		return {z, n, h, c};
	endfunction

endpackage

// File: rtl/cabu8_cb.sv
// CB-prefix unit: rotates, shifts, SWAP, BIT, RES and SET on one byte.
// Uses cabu8_pkg for the response type and group codes.
module cabu8_cb
	import cabu8_pkg::*;
(
	input  logic [7:0] a,
	input  logic [7:0] op,
	input  logic [3:0] flags,
	output rsp_t       rsp
);

	logic [2:0] sel;
	logic [1:0] grp;
	logic       cin;
	logic [7:0] mask;
	logic [7:0] r;
	logic       c;

	assign sel  = op[5:3];
	assign grp  = op[7:6];
	assign cin  = flags[FLAG_C];
	assign mask = 8'd1 << sel;

	always_comb begin
		unique case (sel)
			CB_RLC: begin
				r = {a[6:0], a[7]};
				c = a[7];
			end
			CB_RRC: begin
				r = {a[0], a[7:1]};
				c = a[0];
			end
			CB_RL: begin
				r = {a[6:0], cin};
				c = a[7];
			end
			CB_RR: begin
				r = {cin, a[7:1]};
				c = a[0];
			end
			CB_SLA: begin
				r = {a[6:0], 1'b0};
				c = a[7];
			end
			CB_SRA: begin
				r = {a[7], a[7:1]};
				c = a[0];
			end
			CB_SWAP: begin
				r = {a[3:0], a[7:4]};
				c = 1'b0;
			end
			CB_SRL: begin
				r = {1'b0, a[7:1]};
				c = a[0];
			end
			default: begin
				r = a;
				c = 1'b0;
			end
		endcase
	end

	always_comb begin
		unique case (grp)
			CB_GRP_BIT: begin
				rsp.result         = a;
				rsp.flags_out      = pack_flags((a & mask) == 8'd0, 1'b0, 1'b1, cin);
				rsp.result_written = 1'b0;
			end
			CB_GRP_RES: begin
				rsp.result         = a & ~mask;
				rsp.flags_out      = flags;
				rsp.result_written = 1'b1;
			end
			CB_GRP_SET: begin
				rsp.result         = a | mask;
				rsp.flags_out      = flags;
				rsp.result_written = 1'b1;
			end
			default: begin
				rsp.result         = r;
				rsp.flags_out      = pack_flags(r == 8'd0, 1'b0, 1'b0, c);
				rsp.result_written = 1'b1;
			end
		endcase
	end

endmodule

// File: rtl/cabu8_alu.sv
// Byte ALU: add, subtract, logic, compare, increment and decrement, with
// the CB group handed to cabu8_cb. Uses cabu8_pkg for types and codes.
module cabu8_alu
	import cabu8_pkg::*;
(
	input  req_t req,
	output rsp_t rsp
);

	logic       cin;
	logic       k_add;
	logic       k_sub;
	logic [8:0] sum;
	logic [4:0] sum_lo;
	logic [8:0] diff;
	logic [4:0] diff_lo;
	logic [7:0] inc;
	logic [7:0] dec;
	logic [7:0] a;
	logic [7:0] b;
	rsp_t       cb_rsp;

	assign a     = req.operand_a;
	assign b     = req.operand_b;
	assign cin   = req.flags_in[FLAG_C];
	assign k_add = (req.mode == MODE_ADC) ? cin : 1'b0;
	assign k_sub = (req.mode == MODE_SBC) ? cin : 1'b0;

	assign sum     = {1'b0, a} + {1'b0, b} + {8'd0, k_add};
	assign sum_lo  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, k_add};
	assign diff    = {1'b0, a} - {1'b0, b} - {8'd0, k_sub};
	assign diff_lo = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, k_sub};
	assign inc     = a + 8'd1;
	assign dec     = a - 8'd1;

	cabu8_cb u_cb (
		.a     (a),
		.op    (b),
		.flags (req.flags_in),
		.rsp   (cb_rsp)
	);

	always_comb begin
		rsp.result         = a;
		rsp.flags_out      = req.flags_in;
		rsp.result_written = 1'b0;
		unique case (req.mode)
			MODE_ADD, MODE_ADC: begin
				rsp.result         = sum[7:0];
				rsp.flags_out      = pack_flags(sum[7:0] == 8'd0, 1'b0, sum_lo[4], sum[8]);
				rsp.result_written = 1'b1;
			end
			MODE_SUB, MODE_SBC: begin
				rsp.result         = diff[7:0];
				rsp.flags_out      = pack_flags(diff[7:0] == 8'd0, 1'b1, diff_lo[4], diff[8]);
				rsp.result_written = 1'b1;
			end
			MODE_CP: begin
				rsp.flags_out = pack_flags(diff[7:0] == 8'd0, 1'b1, diff_lo[4], diff[8]);
			end
			MODE_AND: begin
				rsp.result         = a & b;
				rsp.flags_out      = pack_flags((a & b) == 8'd0, 1'b0, 1'b1, 1'b0);
				rsp.result_written = 1'b1;
			end
			MODE_XOR: begin
				rsp.result         = a ^ b;
				rsp.flags_out      = pack_flags((a ^ b) == 8'd0, 1'b0, 1'b0, 1'b0);
				rsp.result_written = 1'b1;
			end
			MODE_OR: begin
				rsp.result         = a | b;
				rsp.flags_out      = pack_flags((a | b) == 8'd0, 1'b0, 1'b0, 1'b0);
				rsp.result_written = 1'b1;
			end
			MODE_INC: begin
				rsp.result         = inc;
				rsp.flags_out      = pack_flags(inc == 8'd0, 1'b0, inc[3:0] == 4'h0, cin);
				rsp.result_written = 1'b1;
			end
			MODE_DEC: begin
				rsp.result         = dec;
				rsp.flags_out      = pack_flags(dec == 8'd0, 1'b1, dec[3:0] == 4'hF, cin);
				rsp.result_written = 1'b1;
			end
			MODE_CB: begin
				rsp = cb_rsp;
			end
			default: begin
				rsp.result         = a;
				rsp.flags_out      = req.flags_in;
				rsp.result_written = 1'b0;
			end
		endcase
	end

endmodule

// File: rtl/cpu_alu_and_bit_unit_8bit_core.sv
// Eight-bit CPU ALU and CB bit unit. One request can be accepted every
// clock cycle while req_stall is low; each request passes an input
// register, one pass of combinational ALU logic and a result register
// that drives rsp. The result register holds a response while rsp_stall
// is high and the input register keeps taking a request behind it, so
// req_stall rises only when both registers are full and the response
// side is stalled. Instantiates cabu8_alu; uses cabu8_pkg and the macro
// header.
`include "cpu_alu_and_bit_unit_8bit_core_macros.svh"

module cpu_alu_and_bit_unit_8bit_core
	import cabu8_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	logic valid_s1;
	logic valid_s2;
	req_t req_s1;
	rsp_t rsp_s2;
	rsp_t alu_rsp;
	logic en_s1;
	logic en_s2;

	assign en_s2     = !valid_s2 || !rsp_stall;
	assign en_s1     = !valid_s1 || en_s2;
	assign req_stall = !en_s1;
	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

	cabu8_alu u_alu (
		.req (req_s1),
		.rsp (alu_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= req_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && req_valid) begin
			req_s1 <= req;
		end
		if (en_s2 && valid_s1) begin
			rsp_s2 <= alu_rsp;
		end
	end

	`CABU8_ASSERT(a_stall_needs_item, req_stall |-> (valid_s1 && valid_s2), "stall while not full")
	`CABU8_ASSERT(a_rsp_held, (valid_s2 && rsp_stall) |=> valid_s2, "stalled response dropped")
	`CABU8_ASSERT(a_s1_advances, (valid_s1 && en_s2) |=> valid_s2, "request lost between stages")
	`CABU8_ASSERT_ALWAYS(a_reset_empty, !arst_n |=> (!valid_s1 && !valid_s2), "reset left requests")

endmodule
